@@ rtl/core/matrix4_inverse_adjugate_defines.svh @@
// Assertion macros for the matrix inverse, included only by m4inv_ctrl.
// No dependencies; files that check their own logic include this header.
`ifndef MATRIX4_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX4_INVERSE_ADJUGATE_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define M4I_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define M4I_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/m4inv_pkg.sv @@
// Shared types, widths and microcode tables for the 4x4 matrix inverse.
// No dependencies; used by the controller, the datapath and the top level.
package m4inv_pkg;

   localparam int ELEM_W     = 32;
   localparam int THR_W      = 31;
   localparam int OPND_W     = 33;   // multiplier operand, signed
   localparam int PROD_W     = 66;
   localparam int SCR_W      = 97;   // 2x2 minors and adjugate entries
   localparam int ACC_W      = 131;  // determinant and accumulator
   localparam int DABS_W     = 130;
   localparam int NUM_W      = 131;
   localparam int REM_W      = 131;
   localparam int SCR_DEPTH  = 28;
   localparam int ROW_W      = 4 * ELEM_W;

   localparam logic [4:0] ADJ_BASE = 5'd12;

   // phase codes inside one controller state
   localparam logic [2:0] PH_RD   = 3'd0;
   localparam logic [2:0] PH_MUL  = 3'd1;
   localparam logic [2:0] PH_ACC  = 3'd2;
   localparam logic [2:0] PH_NUM  = 3'd1;
   localparam logic [2:0] PH_CHK  = 3'd2;
   localparam logic [2:0] PH_STEP = 3'd3;
   localparam logic [2:0] PH_FIN  = 3'd4;

   typedef enum logic [3:0] {
      S_LOAD, S_MIN, S_ADJ, S_DET, S_DABS, S_SCHK, S_DECIDE, S_SING, S_DIV, S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD, OP_RD, OP_MUL, OP_ACC, OP_DABS, OP_SCHK,
      OP_DNUM, OP_DCHK, OP_DSTEP, OP_DFIN, OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CH_ELEM, CH_LO, CH_MID_U, CH_MID_S, CH_HI
   } chunk_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] wr_row;
      logic [3:0] a_addr;
      logic [3:0] b_addr;
      logic [4:0] s_addr;
      chunk_type  chunk;
      logic       neg;
      logic       clr;
      logic       wr_scr;
      logic [4:0] wr_addr;
      logic       wr_det;
      logic [1:0] col;
      logic       emit_sing;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic sing;
      logic out_free;
   } sts_type;

   // column pairs of the 2x2 minors, in the order (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
   localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PAIR_J [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   // adjugate terms: {negate, element index, minor slot}; slots 0..5 rows 0/1,
   // slots 6..11 rows 2/3
   localparam logic [8:0] ADJ_TERM [16][3] = '{
      '{{1'b0, 4'd5 , 4'd11}, {1'b1, 4'd6 , 4'd10}, {1'b0, 4'd7 , 4'd9 }},
      '{{1'b1, 4'd1 , 4'd11}, {1'b0, 4'd2 , 4'd10}, {1'b1, 4'd3 , 4'd9 }},
      '{{1'b0, 4'd13, 4'd5 }, {1'b1, 4'd14, 4'd4 }, {1'b0, 4'd15, 4'd3 }},
      '{{1'b1, 4'd9 , 4'd5 }, {1'b0, 4'd10, 4'd4 }, {1'b1, 4'd11, 4'd3 }},
      '{{1'b1, 4'd4 , 4'd11}, {1'b0, 4'd6 , 4'd8 }, {1'b1, 4'd7 , 4'd7 }},
      '{{1'b0, 4'd0 , 4'd11}, {1'b1, 4'd2 , 4'd8 }, {1'b0, 4'd3 , 4'd7 }},
      '{{1'b1, 4'd12, 4'd5 }, {1'b0, 4'd14, 4'd2 }, {1'b1, 4'd15, 4'd1 }},
      '{{1'b0, 4'd8 , 4'd5 }, {1'b1, 4'd10, 4'd2 }, {1'b0, 4'd11, 4'd1 }},
      '{{1'b0, 4'd4 , 4'd10}, {1'b1, 4'd5 , 4'd8 }, {1'b0, 4'd7 , 4'd6 }},
      '{{1'b1, 4'd0 , 4'd10}, {1'b0, 4'd1 , 4'd8 }, {1'b1, 4'd3 , 4'd6 }},
      '{{1'b0, 4'd12, 4'd4 }, {1'b1, 4'd13, 4'd2 }, {1'b0, 4'd15, 4'd0 }},
      '{{1'b1, 4'd8 , 4'd4 }, {1'b0, 4'd9 , 4'd2 }, {1'b1, 4'd11, 4'd0 }},
      '{{1'b1, 4'd4 , 4'd9 }, {1'b0, 4'd5 , 4'd7 }, {1'b1, 4'd6 , 4'd6 }},
      '{{1'b0, 4'd0 , 4'd9 }, {1'b1, 4'd1 , 4'd7 }, {1'b0, 4'd2 , 4'd6 }},
      '{{1'b1, 4'd12, 4'd3 }, {1'b0, 4'd13, 4'd1 }, {1'b1, 4'd14, 4'd0 }},
      '{{1'b0, 4'd8 , 4'd3 }, {1'b1, 4'd9 , 4'd1 }, {1'b0, 4'd10, 4'd0 }}
   };

endpackage

@@ rtl/core/m4inv_ctrl.sv @@
// Sequencer for the matrix inverse: row loading, multiply-accumulate program,
// division and row emission. Depends on m4inv_pkg and the assertion header.
`include "matrix4_inverse_adjugate_defines.svh"

module m4inv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  m4inv_pkg::sts_type sts,
   output m4inv_pkg::cmd_type cmd
);

   m4inv_pkg::state_type state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] term_ff, term_in;
   logic [1:0] chunk_ff, chunk_in;
   logic [2:0] ph_ff, ph_in;
   logic [4:0] bit_ff, bit_in;
   logic [1:0] rows_ff, rows_in;

   logic [2:0] pair;
   logic [1:0] row_base;
   logic [8:0] adj_t;
   logic       mac_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m4inv_pkg::S_LOAD;
         idx_ff   <= '0;
         term_ff  <= '0;
         chunk_ff <= '0;
         ph_ff    <= m4inv_pkg::PH_RD;
         bit_ff   <= '0;
         rows_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         term_ff  <= term_in;
         chunk_ff <= chunk_in;
         ph_ff    <= ph_in;
         bit_ff   <= bit_in;
         rows_ff  <= rows_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      term_in   = term_ff;
      chunk_in  = chunk_ff;
      ph_in     = ph_ff;
      bit_in    = bit_ff;
      rows_in   = rows_ff;
      cmd       = '0;
      req_stall = 1'b1;
      pair      = (idx_ff < 4'd6) ? idx_ff[2:0] : 3'(idx_ff - 4'd6);
      row_base  = (idx_ff < 4'd6) ? 2'd0 : 2'd2;
      adj_t     = m4inv_pkg::ADJ_TERM[idx_ff][term_ff];
      mac_end   = (ph_ff == m4inv_pkg::PH_ACC);

      // multiply-accumulate phases shared by the three program sections
      case (ph_ff)
         m4inv_pkg::PH_RD:  cmd.op = m4inv_pkg::OP_RD;
         m4inv_pkg::PH_MUL: cmd.op = m4inv_pkg::OP_MUL;
         default:           cmd.op = m4inv_pkg::OP_ACC;
      endcase

      case (state_ff)
         m4inv_pkg::S_LOAD: begin
            cmd.op     = m4inv_pkg::OP_IDLE;
            req_stall  = 1'b0;
            if (req_valid) begin
               cmd.op     = m4inv_pkg::OP_LOAD;
               cmd.wr_row = rows_ff;
               rows_in    = rows_ff + 2'd1;
               if (rows_ff == 2'd3) begin
                  state_in = m4inv_pkg::S_MIN;
                  idx_in   = '0;
                  term_in  = '0;
                  chunk_in = '0;
                  ph_in    = m4inv_pkg::PH_RD;
               end
            end
         end
         m4inv_pkg::S_MIN: begin
            cmd.chunk = m4inv_pkg::CH_ELEM;
            if (term_ff == 2'd0) begin
               cmd.a_addr = {row_base, m4inv_pkg::PAIR_I[pair]};
               cmd.b_addr = {row_base + 2'd1, m4inv_pkg::PAIR_J[pair]};
            end else begin
               cmd.a_addr = {row_base + 2'd1, m4inv_pkg::PAIR_I[pair]};
               cmd.b_addr = {row_base, m4inv_pkg::PAIR_J[pair]};
            end
            cmd.neg     = term_ff[0];
            cmd.clr     = (term_ff == 2'd0);
            cmd.wr_scr  = (term_ff == 2'd1);
            cmd.wr_addr = {1'b0, idx_ff};
            ph_in = mac_end ? m4inv_pkg::PH_RD : ph_ff + 3'd1;
            if (mac_end) begin
               if (term_ff == 2'd1) begin
                  term_in = '0;
                  if (idx_ff == 4'd11) begin
                     state_in = m4inv_pkg::S_ADJ;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end
         end
         m4inv_pkg::S_ADJ: begin
            cmd.a_addr  = adj_t[7:4];
            cmd.s_addr  = {1'b0, adj_t[3:0]};
            cmd.neg     = adj_t[8];
            cmd.chunk   = (chunk_ff == 2'd0) ? m4inv_pkg::CH_LO : m4inv_pkg::CH_MID_S;
            cmd.clr     = (term_ff == 2'd0) && (chunk_ff == 2'd0);
            cmd.wr_scr  = (term_ff == 2'd2) && (chunk_ff == 2'd1);
            cmd.wr_addr = m4inv_pkg::ADJ_BASE + {1'b0, idx_ff};
            ph_in = mac_end ? m4inv_pkg::PH_RD : ph_ff + 3'd1;
            if (mac_end) begin
               if (chunk_ff == 2'd0) begin
                  chunk_in = 2'd1;
               end else begin
                  chunk_in = '0;
                  if (term_ff == 2'd2) begin
                     term_in = '0;
                     if (idx_ff == 4'd15) begin
                        state_in = m4inv_pkg::S_DET;
                        idx_in   = '0;
                     end else begin
                        idx_in = idx_ff + 4'd1;
                     end
                  end else begin
                     term_in = term_ff + 2'd1;
                  end
               end
            end
         end
         m4inv_pkg::S_DET: begin
            // det = sum over j of a[0][j] * adj[j][0]
            cmd.a_addr = {2'd0, idx_ff[1:0]};
            cmd.s_addr = m4inv_pkg::ADJ_BASE + {1'b0, idx_ff[1:0], 2'b00};
            case (chunk_ff)
               2'd0:    cmd.chunk = m4inv_pkg::CH_LO;
               2'd1:    cmd.chunk = m4inv_pkg::CH_MID_U;
               default: cmd.chunk = m4inv_pkg::CH_HI;
            endcase
            cmd.clr    = (idx_ff[1:0] == 2'd0) && (chunk_ff == 2'd0);
            cmd.wr_det = (idx_ff[1:0] == 2'd3) && (chunk_ff == 2'd2);
            ph_in = mac_end ? m4inv_pkg::PH_RD : ph_ff + 3'd1;
            if (mac_end) begin
               if (chunk_ff != 2'd2) begin
                  chunk_in = chunk_ff + 2'd1;
               end else begin
                  chunk_in = '0;
                  if (idx_ff[1:0] == 2'd3) begin
                     state_in = m4inv_pkg::S_DABS;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
            end
         end
         m4inv_pkg::S_DABS: begin
            cmd.op   = m4inv_pkg::OP_DABS;
            state_in = m4inv_pkg::S_SCHK;
         end
         m4inv_pkg::S_SCHK: begin
            cmd.op   = m4inv_pkg::OP_SCHK;
            state_in = m4inv_pkg::S_DECIDE;
         end
         m4inv_pkg::S_DECIDE: begin
            cmd.op   = m4inv_pkg::OP_IDLE;
            idx_in   = '0;
            ph_in    = m4inv_pkg::PH_RD;
            state_in = sts.sing ? m4inv_pkg::S_SING : m4inv_pkg::S_DIV;
         end
         m4inv_pkg::S_SING: begin
            cmd.op = m4inv_pkg::OP_IDLE;
            if (sts.out_free) begin
               cmd.op        = m4inv_pkg::OP_EMIT;
               cmd.emit_sing = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = m4inv_pkg::S_LOAD;
            end
         end
         m4inv_pkg::S_DIV: begin
            cmd.s_addr = m4inv_pkg::ADJ_BASE + {1'b0, idx_ff};
            cmd.col    = idx_ff[1:0];
            case (ph_ff)
               m4inv_pkg::PH_RD: begin
                  cmd.op = m4inv_pkg::OP_RD;
                  ph_in  = m4inv_pkg::PH_NUM;
               end
               m4inv_pkg::PH_NUM: begin
                  cmd.op = m4inv_pkg::OP_DNUM;
                  ph_in  = m4inv_pkg::PH_CHK;
               end
               m4inv_pkg::PH_CHK: begin
                  cmd.op = m4inv_pkg::OP_DCHK;
                  bit_in = '0;
                  ph_in  = m4inv_pkg::PH_STEP;
               end
               m4inv_pkg::PH_STEP: begin
                  cmd.op = m4inv_pkg::OP_DSTEP;
                  bit_in = bit_ff + 5'd1;
                  if (bit_ff == 5'd31) begin
                     ph_in = m4inv_pkg::PH_FIN;
                  end
               end
               default: begin
                  cmd.op = m4inv_pkg::OP_DFIN;
                  ph_in  = m4inv_pkg::PH_RD;
                  if (idx_ff[1:0] == 2'd3) begin
                     state_in = m4inv_pkg::S_EMIT;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
            endcase
         end
         m4inv_pkg::S_EMIT: begin
            cmd.op = m4inv_pkg::OP_IDLE;
            if (sts.out_free) begin
               cmd.op        = m4inv_pkg::OP_EMIT;
               cmd.emit_last = (idx_ff == 4'd15);
               ph_in         = m4inv_pkg::PH_RD;
               if (idx_ff == 4'd15) begin
                  state_in = m4inv_pkg::S_LOAD;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = m4inv_pkg::S_DIV;
               end
            end
         end
         default: begin
            cmd.op   = m4inv_pkg::OP_IDLE;
            state_in = m4inv_pkg::S_LOAD;
         end
      endcase
   end

   `M4I_ASSERT_NOW(a_rows_only_loading, rows_ff != 2'd0, state_ff == m4inv_pkg::S_LOAD, "partial matrix outside load state")
   `M4I_ASSERT_NOW(a_emit_needs_room, cmd.op == m4inv_pkg::OP_EMIT, sts.out_free, "emit while output register is held")
   `M4I_ASSERT_NEXT(a_last_returns, cmd.op == m4inv_pkg::OP_EMIT && cmd.emit_last, state_ff == m4inv_pkg::S_LOAD && rows_ff == 2'd0, "no return to loading after last row")

endmodule

@@ rtl/core/m4inv_dp.sv @@
// Datapath of the matrix inverse: row memory, scratch memory, one 33x33
// multiplier with a wide accumulator, a radix-2 divider and the output register.
// Depends on m4inv_pkg; driven by m4inv_ctrl through cmd_type.
module m4inv_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  m4inv_pkg::cmd_type       cmd,
   output m4inv_pkg::sts_type       sts,
   input  logic signed [31:0]       req_elem_col0,
   input  logic signed [31:0]       req_elem_col1,
   input  logic signed [31:0]       req_elem_col2,
   input  logic signed [31:0]       req_elem_col3,
   input  logic                     csr_valid,
   input  logic [30:0]              csr_det_threshold,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_inv_col0,
   output logic signed [31:0]       rsp_inv_col1,
   output logic signed [31:0]       rsp_inv_col2,
   output logic signed [31:0]       rsp_inv_col3,
   output logic                     rsp_singular,
   output logic                     rsp_saturated,
   output logic                     rsp_last_row
);

   localparam int EW = m4inv_pkg::ELEM_W;

   logic [m4inv_pkg::ROW_W-1:0] mat_mem_ff [4];
   logic [m4inv_pkg::SCR_W-1:0] scr_mem_ff [m4inv_pkg::SCR_DEPTH];

   logic [m4inv_pkg::ROW_W-1:0] a_row_ff, b_row_ff;
   logic [1:0]                  a_col_ff, b_col_ff;
   logic [m4inv_pkg::SCR_W-1:0] scr_q_ff;

   logic signed [m4inv_pkg::PROD_W-1:0] prod_ff;
   logic signed [m4inv_pkg::ACC_W-1:0]  acc_ff, acc_in, det_ff;
   logic [m4inv_pkg::DABS_W-1:0]        dabs_ff;
   logic                                dneg_ff, sing_ff;
   logic [m4inv_pkg::THR_W-1:0]         thr_ff;

   logic [m4inv_pkg::NUM_W-1:0]  num_ff;
   logic                         neg_ff, big_ff;
   logic [m4inv_pkg::REM_W-1:0]  rem_ff;
   logic [EW-1:0]                nb_ff, q_ff;

   logic [EW-1:0] row_ff [4];
   logic          rowsat_ff;

   logic                     rsp_valid_ff;
   logic [EW-1:0]            out_ff [4];
   logic                     out_sing_ff, out_sat_ff, out_last_ff;

   logic [EW-1:0]                        a_elem, b_elem;
   logic signed [m4inv_pkg::OPND_W-1:0]  opa, opb;
   logic signed [m4inv_pkg::ACC_W-1:0]   pext, pshift, pterm;
   logic [m4inv_pkg::SCR_W-1:0]          cabs;
   logic                                 cneg;
   logic [m4inv_pkg::DABS_W:0]           den2;
   logic [m4inv_pkg::REM_W:0]            rem2, diff;
   logic [EW-1:0]                        fin_v;
   logic                                 fin_s;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         thr_ff <= csr_det_threshold;
      end
   end

   // row memory and scratch memory
   always_ff @(posedge clock) begin
      if (cmd.op == m4inv_pkg::OP_LOAD) begin
         mat_mem_ff[cmd.wr_row] <= {req_elem_col3, req_elem_col2, req_elem_col1, req_elem_col0};
      end
      if (cmd.op == m4inv_pkg::OP_RD) begin
         a_row_ff <= mat_mem_ff[cmd.a_addr[3:2]];
         b_row_ff <= mat_mem_ff[cmd.b_addr[3:2]];
         a_col_ff <= cmd.a_addr[1:0];
         b_col_ff <= cmd.b_addr[1:0];
         scr_q_ff <= scr_mem_ff[cmd.s_addr];
      end
      if (cmd.op == m4inv_pkg::OP_ACC && cmd.wr_scr) begin
         scr_mem_ff[cmd.wr_addr] <= acc_in[m4inv_pkg::SCR_W-1:0];
      end
   end

   assign a_elem = a_row_ff[{a_col_ff, 5'b0} +: EW];
   assign b_elem = b_row_ff[{b_col_ff, 5'b0} +: EW];

   always_comb begin
      opa = {a_elem[EW-1], a_elem};
      case (cmd.chunk)
         m4inv_pkg::CH_ELEM:  opb = {b_elem[EW-1], b_elem};
         m4inv_pkg::CH_LO:    opb = {1'b0, scr_q_ff[31:0]};
         m4inv_pkg::CH_MID_U: opb = {1'b0, scr_q_ff[63:32]};
         m4inv_pkg::CH_MID_S: opb = scr_q_ff[64:32];
         m4inv_pkg::CH_HI:    opb = scr_q_ff[96:64];
         default:             opb = '0;
      endcase
   end

   always_comb begin
      pext = {{(m4inv_pkg::ACC_W - m4inv_pkg::PROD_W){prod_ff[m4inv_pkg::PROD_W-1]}}, prod_ff};
      case (cmd.chunk)
         m4inv_pkg::CH_MID_U, m4inv_pkg::CH_MID_S: pshift = pext <<< 32;
         m4inv_pkg::CH_HI:                         pshift = pext <<< 64;
         default:                                  pshift = pext;
      endcase
      pterm  = cmd.neg ? -pshift : pshift;
      acc_in = (cmd.clr ? '0 : acc_ff) + pterm;
   end

   // multiply, accumulate, determinant
   always_ff @(posedge clock) begin
      if (cmd.op == m4inv_pkg::OP_MUL) begin
         prod_ff <= opa * opb;
      end
      if (cmd.op == m4inv_pkg::OP_ACC) begin
         acc_ff <= acc_in;
         if (cmd.wr_det) begin
            det_ff <= acc_in;
         end
      end
      if (cmd.op == m4inv_pkg::OP_DABS) begin
         dneg_ff <= det_ff[m4inv_pkg::ACC_W-1];
         dabs_ff <= det_ff[m4inv_pkg::ACC_W-1] ? m4inv_pkg::DABS_W'(-det_ff)
                                                : m4inv_pkg::DABS_W'(det_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sing_ff <= 1'b0;
      end else if (cmd.op == m4inv_pkg::OP_SCHK) begin
         sing_ff <= (dabs_ff <= m4inv_pkg::DABS_W'({thr_ff, 48'b0}));
      end
   end

   // divider: |C| * 2^33 + |D| over 2|D|, one quotient bit a cycle
   assign cneg = scr_q_ff[m4inv_pkg::SCR_W-1];
   assign cabs = cneg ? -scr_q_ff : scr_q_ff;
   assign den2 = {dabs_ff, 1'b0};
   assign rem2 = {rem_ff, nb_ff[EW-1]};
   assign diff = rem2 - {1'b0, den2};

   always_comb begin
      fin_s = 1'b0;
      fin_v = q_ff;
      if (big_ff) begin
         fin_s = 1'b1;
         fin_v = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (neg_ff) begin
         if (q_ff > 32'h8000_0000) begin
            fin_s = 1'b1;
            fin_v = 32'h8000_0000;
         end else begin
            fin_v = -q_ff;
         end
      end else if (q_ff > 32'h7FFF_FFFF) begin
         fin_s = 1'b1;
         fin_v = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         m4inv_pkg::OP_DNUM: begin
            num_ff <= {1'b0, cabs[m4inv_pkg::SCR_W-2:0], 33'b0} + {1'b0, dabs_ff};
            neg_ff <= cneg ^ dneg_ff;
         end
         m4inv_pkg::OP_DCHK: begin
            big_ff <= {32'b0, num_ff} >= {den2, 32'b0};
            rem_ff <= {32'b0, num_ff[m4inv_pkg::NUM_W-1:32]};
            nb_ff  <= num_ff[31:0];
            q_ff   <= '0;
         end
         m4inv_pkg::OP_DSTEP: begin
            rem_ff <= diff[m4inv_pkg::REM_W] ? rem2[m4inv_pkg::REM_W-1:0]
                                             : diff[m4inv_pkg::REM_W-1:0];
            q_ff   <= {q_ff[EW-2:0], ~diff[m4inv_pkg::REM_W]};
            nb_ff  <= {nb_ff[EW-2:0], 1'b0};
         end
         m4inv_pkg::OP_DFIN: begin
            row_ff[cmd.col] <= fin_v;
            rowsat_ff       <= (cmd.col == 2'd0) ? fin_s : (rowsat_ff | fin_s);
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == m4inv_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == m4inv_pkg::OP_EMIT) begin
         for (int k = 0; k < 4; k++) begin
            out_ff[k] <= cmd.emit_sing ? '0 : row_ff[k];
         end
         out_sing_ff <= cmd.emit_sing;
         out_sat_ff  <= cmd.emit_sing ? 1'b0 : rowsat_ff;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign sts.sing     = sing_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inv_col0  = out_ff[0];
   assign rsp_inv_col1  = out_ff[1];
   assign rsp_inv_col2  = out_ff[2];
   assign rsp_inv_col3  = out_ff[3];
   assign rsp_singular  = out_sing_ff;
   assign rsp_saturated = out_sat_ff;
   assign rsp_last_row  = out_last_ff;

endmodule

@@ rtl/core/matrix4_inverse_adjugate.sv @@
// Top level of the 4x4 Q16.16 matrix inverse through the adjugate.
// Depends on m4inv_pkg, m4inv_ctrl and m4inv_dp.
//
// Usage:
//   req_* takes one matrix row per beat, row 0 first; a beat moves when
//   req_valid is high and req_stall is low. Rows one to three give no result.
//   After the fourth row the block stalls its input while one shared 33x33
//   multiplier runs 132 multiply steps, each a read, a multiply and an
//   accumulate (2x2 minors, adjugate, determinant), then a radix-2 divider
//   works out the inverse entries one after another, one row at a time.
//   rsp_* gives four rows of the inverse, last_row on the fourth, or a single
//   beat with singular set when |det| is within csr_det_threshold.
//   rsp_stall holds the output register; divisions of the next row go on
//   behind it. Loading of the next matrix starts once the last beat sits in
//   the output register.
//   csr_* writes the threshold at any beat; csr_ready is always high.
//   Reset (synchronous) clears the row count, the threshold and rsp_valid.
module matrix4_inverse_adjugate (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_elem_col0,
   input  logic signed [31:0] req_elem_col1,
   input  logic signed [31:0] req_elem_col2,
   input  logic signed [31:0] req_elem_col3,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_inv_col0,
   output logic signed [31:0] rsp_inv_col1,
   output logic signed [31:0] rsp_inv_col2,
   output logic signed [31:0] rsp_inv_col3,
   output logic               rsp_singular,
   output logic               rsp_saturated,
   output logic               rsp_last_row,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_det_threshold
);

   m4inv_pkg::cmd_type cmd;
   m4inv_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   m4inv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   m4inv_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_elem_col0     (req_elem_col0),
      .req_elem_col1     (req_elem_col1),
      .req_elem_col2     (req_elem_col2),
      .req_elem_col3     (req_elem_col3),
      .csr_valid         (csr_valid),
      .csr_det_threshold (csr_det_threshold),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inv_col0      (rsp_inv_col0),
      .rsp_inv_col1      (rsp_inv_col1),
      .rsp_inv_col2      (rsp_inv_col2),
      .rsp_inv_col3      (rsp_inv_col3),
      .rsp_singular      (rsp_singular),
      .rsp_saturated     (rsp_saturated),
      .rsp_last_row      (rsp_last_row)
   );

endmodule

@@ test/matrix4_inverse_adjugate_test.sv @@
// Self-checking bench for matrix4_inverse_adjugate: directed matrices, then random ones.
// Needs only the RTL; typed rows or an exact wide-integer adjugate model check each beat.

module matrix4_inverse_adjugate_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [199:0] wide_type;
   typedef logic [3:0][31:0] row_type;

   typedef struct packed {
      row_type col;
      logic singular;
      logic saturated;
      logic last_row;
   } inv_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_elem_col0 = '0, req_elem_col1 = '0;
   logic signed [31:0] req_elem_col2 = '0, req_elem_col3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_inv_col0, rsp_inv_col1, rsp_inv_col2, rsp_inv_col3;
   logic rsp_singular, rsp_saturated, rsp_last_row;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [30:0] csr_det_threshold = '0;

   matrix4_inverse_adjugate DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // predictor state
   logic signed [31:0] mat_store [16];
   int unsigned rows_filled = 0;
   logic [30:0] threshold = '0;
   inv_row_type inverse_rows_q [$];
   int errors = 0;
   bit quiet = 0;

   function automatic wide_type minor3(int p, int q);
      wide_type e [3][3];
      int r, c, rr;
      int cc;
      rr = 0;
      for (r = 0; r < 4; r++) begin
         if (r != p) begin
            cc = 0;
            for (c = 0; c < 4; c++) begin
               if (c != q) begin
                  e[rr][cc] = mat_store[r*4 + c];
                  cc++;
               end
            end
            rr++;
         end
      end
      return e[0][0] * (e[1][1]*e[2][2] - e[1][2]*e[2][1])
           - e[0][1] * (e[1][0]*e[2][2] - e[1][2]*e[2][0])
           + e[0][2] * (e[1][0]*e[2][1] - e[1][1]*e[2][0]);
   endfunction

   // Store one row; on the fourth, push the inverse rows it yields, or one singular beat.
   function automatic void load_matrix_row(row_type r);
      wide_type mnr [4][4];
      wide_type det, dabs, lim, cof, num, q, a0;
      inv_row_type o;
      bit neg;
      int i, j;
      for (j = 0; j < 4; j++) mat_store[rows_filled*4 + j] = r[j];
      rows_filled = (rows_filled + 1) % 4;
      if (rows_filled != 0) return;
      for (i = 0; i < 4; i++)
         for (j = 0; j < 4; j++) mnr[i][j] = minor3(i, j);
      det = 0;
      for (j = 0; j < 4; j++) begin
         a0 = mat_store[j];
         det = (j % 2) ? det - a0*mnr[0][j] : det + a0*mnr[0][j];
      end
      dabs = (det < 0) ? -det : det;
      lim = {169'd0, threshold};
      lim = lim <<< 48;
      if (dabs <= lim) begin
         o = '0;
         o.singular = 1'b1;
         o.last_row = 1'b1;
         inverse_rows_q.push_back(o);
         return;
      end
      for (i = 0; i < 4; i++) begin
         o = '0;
         for (j = 0; j < 4; j++) begin
            cof = ((i + j) % 2) ? -mnr[j][i] : mnr[j][i];
            neg = (cof < 0) != (det < 0);
            num = (cof < 0) ? -cof : cof;
            num = num <<< 32;
            q = (2*num + dabs) / (2*dabs);
            if (!neg && q > 64'sh7FFFFFFF) begin
               o.saturated = 1'b1;
               o.col[j] = 32'h7FFFFFFF;
            end else if (neg && q > 64'sh80000000) begin
               o.saturated = 1'b1;
               o.col[j] = 32'h80000000;
            end else begin
               o.col[j] = neg ? 32'(-q) : 32'(q);
            end
         end
         o.last_row = (i == 3);
         inverse_rows_q.push_back(o);
      end
   endfunction

   // response side: check beats, stall in random bursts
   initial begin
      int burst;
      inv_row_type want;
      burst = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (inverse_rows_q.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               want = inverse_rows_q.pop_front();
               if (rsp_inv_col0 !== want.col[0]) begin
                  $error("inv_col0 expected %h got %h", want.col[0], rsp_inv_col0); errors++;
               end
               if (rsp_inv_col1 !== want.col[1]) begin
                  $error("inv_col1 expected %h got %h", want.col[1], rsp_inv_col1); errors++;
               end
               if (rsp_inv_col2 !== want.col[2]) begin
                  $error("inv_col2 expected %h got %h", want.col[2], rsp_inv_col2); errors++;
               end
               if (rsp_inv_col3 !== want.col[3]) begin
                  $error("inv_col3 expected %h got %h", want.col[3], rsp_inv_col3); errors++;
               end
               if (rsp_singular !== want.singular) begin
                  $error("singular expected %b got %b", want.singular, rsp_singular); errors++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated expected %b got %b", want.saturated, rsp_saturated);
                  errors++;
               end
               if (rsp_last_row !== want.last_row) begin
                  $error("last_row expected %b got %b", want.last_row, rsp_last_row); errors++;
               end
            end
         end
         if (burst > 0) burst--;
         else if (!quiet && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 17);
         rsp_stall <= (burst > 0);
      end
   end

   task automatic send_row(row_type r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_elem_col3, req_elem_col2, req_elem_col1, req_elem_col0} <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_matrix_row(r);
   endtask

   // drain, let the block settle, then write the threshold
   task automatic set_threshold(logic [30:0] v);
      req_valid <= 1'b0;
      while (inverse_rows_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_det_threshold <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      threshold = v;
   endtask

   function automatic logic [31:0] rand_elem(int kind);
      case (kind)
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
         default: return 32'($urandom_range(0, 32'h3FF)) - 32'h200;
      endcase
   endfunction

   localparam logic [31:0] MX = 32'h7FFFFFFF;
   localparam logic [31:0] MN = 32'h80000000;
   localparam logic [31:0] ONE = 32'h00010000;

   // directed matrices, rows listed col3..col0
   localparam row_type DIRECTED [24] = '{
      {32'd0, 32'd0, 32'd0, ONE}, {32'd0, 32'd0, ONE, 32'd0},
      {32'd0, ONE, 32'd0, 32'd0}, {ONE, 32'd0, 32'd0, 32'd0},
      '0, '0, '0, '0,
      {32'd0, 32'd0, 32'd0, MN}, {32'd0, 32'd0, MN, 32'd0},
      {32'd0, MN, 32'd0, 32'd0}, {MN, 32'd0, 32'd0, 32'd0},
      {32'd0, 32'd0, 32'd0, 32'd1}, {32'd0, 32'd0, 32'd1, 32'd0},
      {32'd0, 32'd1, 32'd0, 32'd0}, {32'd1, 32'd0, 32'd0, 32'd0},
      {MX, MX, MX, MX}, {MX, MX, MX, MX}, {MX, MX, MX, MX}, {MX, MX, MX, MX},
      {32'd1, 32'd0, MN, MX}, {32'd0, MX, 32'd1, MN},
      {MN, 32'd1, MX, 32'd0}, {MX, MN, 32'd0, 32'd1}
   };
   // per directed matrix: typed in, singular, diagonal value, saturated
   localparam bit DIR_TYPED [6] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
   localparam bit DIR_SING [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
   localparam logic [31:0] DIR_DIAG [6] = '{ONE, 32'd0, 32'hFFFFFFFE, MX, 32'd0, 32'd0};
   localparam bit DIR_SAT [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

   initial begin
      inv_row_type o;
      row_type r;
      int m, i, kind, k, phase;
      row_type first_row;
      logic [30:0] thr_list [4];
      thr_list = '{31'h7FFFFFFF, 31'd0, 31'h00010000, 31'd0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_threshold(31'd0);

      for (m = 0; m < 6; m++) begin
         for (i = 0; i < 4; i++) begin
            send_row(DIRECTED[m*4 + i]);
            if (i == 3 && DIR_TYPED[m]) begin
               // replace the predicted rows with the hand-written ones
               repeat (DIR_SING[m] ? 1 : 4) void'(inverse_rows_q.pop_back());
               if (DIR_SING[m]) begin
                  o = '0; o.singular = 1'b1; o.last_row = 1'b1;
                  inverse_rows_q.push_back(o);
               end else begin
                  for (k = 0; k < 4; k++) begin
                     o = '0;
                     o.col[k] = DIR_DIAG[m];
                     o.saturated = DIR_SAT[m];
                     o.last_row = (k == 3);
                     inverse_rows_q.push_back(o);
                  end
               end
            end
         end
      end

      thr_list[1] = 31'($urandom_range(0, 32'h7FFFFFFF));
      for (phase = 0; phase < 4; phase++) begin
         set_threshold(thr_list[phase]);
         for (m = 0; m < 11; m++) begin
            if (phase == 3 && m == 1) quiet = 1;
            if (phase == 2 && m == 5) begin
               // hold off until the block has drained
               req_valid <= 1'b0;
               while (inverse_rows_q.size() != 0) @(posedge clock);
            end
            kind = $urandom_range(0, 3);
            for (i = 0; i < 4; i++) begin
               for (k = 0; k < 4; k++) r[k] = rand_elem(kind == 3 ? 2 : kind);
               if (i == 0) first_row = r;
               // rank-deficient: repeat the first row
               if (kind == 3 && i == 3) r = first_row;
               send_row(r);
            end
         end
      end

      req_valid <= 1'b0;
      while (inverse_rows_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/m4inv_pkg.sv
rtl/core/m4inv_ctrl.sv
rtl/core/m4inv_dp.sv
rtl/core/matrix4_inverse_adjugate.sv
test/matrix4_inverse_adjugate_test.sv
